[rtl/core/tle_pkg.sv]
// ============================================================================
// tle_pkg
// Shared types, codes and constants of the line editor.
// ============================================================================
package tle_pkg;

    // Line length counter and limit width
    localparam int LINE_W = 12;
    localparam logic [LINE_W-1:0] MAX_LINE = LINE_W'(2048);
    localparam logic [LINE_W-1:0] LIMIT_RESET = LINE_W'(2048);

    // Results buffered for one item
    localparam int RUN_DEPTH = 4;
    localparam int RUN_CNT_W = 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ECHO  = 2'd0,
        CFG_CRLF  = 2'd1,
        CFG_LIMIT = 2'd2
    } t_cfg_idx;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    // Control characters
    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // Erase sequence: backspace, ESC [ J
    localparam logic [7:0] ERASE_SEQ [RUN_DEPTH] = '{8'h08, 8'h1B, 8'h5B, 8'h4A};

    // Input item
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_error;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]        result_kind;
        logic [7:0]        byte_value;
        logic [LINE_W-1:0] position;
        logic              last_of_run;
    } t_out_item;

    // All results of one item
    typedef struct packed {
        logic [RUN_CNT_W-1:0]            count;
        t_out_item [RUN_DEPTH-1:0]       items;
    } t_run;

    // Configuration register set
    typedef struct packed {
        logic              echo_enable;
        logic              crlf_enable;
        logic [LINE_W-1:0] line_limit;
    } t_cfg;

    // Builds one result with the run end mark cleared.
    function automatic t_out_item make_result(t_kind kind, logic [7:0] value,
                                              logic [LINE_W-1:0] pos);
        t_out_item r;
        r.result_kind = kind;
        r.byte_value  = value;
        r.position    = pos;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

[rtl/core/tle_cfg_regs.sv]
// ============================================================================
// tle_cfg_regs
// Configuration registers of the line editor, written by index.
// ============================================================================
module tle_cfg_regs
    import tle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LINE_W-1:0]    i_cfg_data,
    output logic                 o_cfg_ready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken at once.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register select; unused indexes are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ECHO:  n_cfg.echo_enable = i_cfg_data[0];
                CFG_CRLF:  n_cfg.crlf_enable = i_cfg_data[0];
                CFG_LIMIT: n_cfg.line_limit  = i_cfg_data;
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.echo_enable <= 1'b1;
            r_cfg.crlf_enable <= 1'b1;
            r_cfg.line_limit  <= LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/core/tle_decode.sv]
// ============================================================================
// tle_decode
// Edits one received byte into the current line and builds its results.
// Holds the character count of the line being assembled.
// ============================================================================
module tle_decode
    import tle_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_run     o_run
);

    logic [LINE_W-1:0]    r_count;
    logic [LINE_W-1:0]    n_count;
    logic [LINE_W-1:0]    lim;
    logic [LINE_W-1:0]    count_inc;
    logic [RUN_CNT_W-1:0] n;
    t_out_item [RUN_DEPTH-1:0] items;

    // Effective limit: zero acts as one, large values clamp to the buffer size.
    always_comb begin
        if (i_cfg.line_limit == '0) begin
            lim = LINE_W'(1);
        end else if (i_cfg.line_limit > MAX_LINE) begin
            lim = MAX_LINE;
        end else begin
            lim = i_cfg.line_limit;
        end
    end

    assign count_inc = r_count + LINE_W'(1);

    // Result list and next count for the current byte.
    always_comb begin
        items   = '0;
        n       = '0;
        n_count = r_count;
        if (i_item.rx_error) begin
            items[0] = make_result(KIND_END, 8'h00, r_count);
            n        = RUN_CNT_W'(1);
            n_count  = '0;
        end else if (i_item.rx_byte == BYTE_BS) begin
            if (r_count != '0) begin
                if (i_cfg.echo_enable) begin
                    for (int k = 0; k < RUN_DEPTH; k++) begin
                        items[k] = make_result(KIND_ECHO, ERASE_SEQ[k], '0);
                    end
                    n = RUN_CNT_W'(RUN_DEPTH);
                end
                n_count = r_count - LINE_W'(1);
            end
        end else if (i_item.rx_byte == BYTE_CR) begin
            if (i_cfg.echo_enable) begin
                items[0] = make_result(KIND_ECHO, BYTE_CR, '0);
                if (i_cfg.crlf_enable) begin
                    items[1] = make_result(KIND_ECHO, BYTE_LF, '0);
                    items[2] = make_result(KIND_END, 8'h00, r_count);
                    n        = RUN_CNT_W'(3);
                end else begin
                    items[1] = make_result(KIND_END, 8'h00, r_count);
                    n        = RUN_CNT_W'(2);
                end
            end else begin
                items[0] = make_result(KIND_END, 8'h00, r_count);
                n        = RUN_CNT_W'(1);
            end
            n_count = '0;
        end else begin
            // Ordinary character: optional echo, store, then a forced end at the limit.
            if (i_cfg.echo_enable) begin
                items[0] = make_result(KIND_ECHO, i_item.rx_byte, '0);
                items[1] = make_result(KIND_STORE, i_item.rx_byte, r_count);
                n        = RUN_CNT_W'(2);
            end else begin
                items[0] = make_result(KIND_STORE, i_item.rx_byte, r_count);
                n        = RUN_CNT_W'(1);
            end
            n_count = count_inc;
            if (count_inc >= lim) begin
                items[n[1:0]] = make_result(KIND_END, 8'h00, count_inc);
                n             = n + RUN_CNT_W'(1);
                n_count       = '0;
            end
        end
        // Mark the final result of the run.
        for (int k = 0; k < RUN_DEPTH; k++) begin
            items[k].last_of_run = (n != '0) && (RUN_CNT_W'(k) == n - RUN_CNT_W'(1));
        end
    end

    assign o_run.count = n;
    assign o_run.items = items;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step) begin
            r_count <= n_count;
        end
    end

endmodule

[rtl/core/tle_run_buf.sv]
// ============================================================================
// tle_run_buf
// Result register that holds the results of one item and sends them one
// per cycle while the output is not stalled.
// ============================================================================
module tle_run_buf
    import tle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_run      i_run,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic [RUN_CNT_W-1:0]      r_cnt;
    logic [RUN_CNT_W-1:0]      n_cnt;
    t_out_item [RUN_DEPTH-1:0] r_items;
    t_out_item [RUN_DEPTH-1:0] n_items;
    logic                      take;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_items[0];
    assign take        = o_out_valid && !i_out_stall;

    // A new run may enter when no result is held or the last held result leaves in this cycle.
    assign o_free = (r_cnt == '0) || ((r_cnt == RUN_CNT_W'(1)) && take);

    // Shift the run down as results leave; load a fresh run when free.
    always_comb begin
        n_cnt   = r_cnt;
        n_items = r_items;
        if (take) begin
            for (int k = 0; k < RUN_DEPTH - 1; k++) begin
                n_items[k] = r_items[k+1];
            end
            n_cnt = r_cnt - RUN_CNT_W'(1);
        end
        if (i_load) begin
            n_items = i_run.items;
            n_cnt   = i_run.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_items <= n_items;
    end

endmodule

[rtl/core/tty_line_editor.sv]
// ============================================================================
// tty_line_editor
// Cooked-mode line editor for bytes received from a UART.
// ============================================================================
// Each accepted item is one received byte with its error flag. It passes an
// input register, is edited against the current character count, and its
// results (echo bytes, a store with its line index, a line end with the
// length) land in a four-entry result register that sends one result per
// cycle while the output is not stalled. An item that causes at most one
// result lets the next item in as that result leaves, so such items can be
// accepted back to back; an item that causes more results (at most four, for
// the erase sequence of a backspace) holds the result register until they
// have left, and the input side stalls meanwhile. Configuration registers
// are written through their own port, always ready.
module tty_line_editor
    import tle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LINE_W-1:0]    i_cfg_data
);

    logic     r_in_valid;
    t_in_item r_in_item;
    logic     step;
    logic     run_free;
    t_cfg     cfg;
    t_run     run;

    // Configuration registers.
    tle_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // The held item moves on when the result register can take its run.
    assign step       = r_in_valid && run_free;
    assign o_in_stall = r_in_valid && !run_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_data;
        end
    end

    // Line editing and count.
    tle_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in_item),
        .i_cfg   (cfg),
        .o_run   (run)
    );

    // Result register and output channel.
    tle_run_buf u_run_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && (run.count != '0)),
        .i_run       (run),
        .o_free      (run_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
